/* src/osa_pkg.sv */
// Shared constants, types and codes of the edit distance block.
`timescale 1ns / 1ps

package osa_pkg;

  // Longest pattern or candidate that is compared; longer strings are cut and flagged.
  localparam int MAX_LEN = 64;

  localparam int CHAR_W = 8;
  localparam int DIST_W = 7;
  localparam int DIST_MAX = 127;

  // Column cells run from 0 to MAX_LEN, pattern bytes from 0 to MAX_LEN-1.
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int PW = $clog2(MAX_LEN);

  // Meaning of the op field of an input beat.
  localparam logic OP_PATTERN   = 1'b0;
  localparam logic OP_CANDIDATE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FIN
  } osa_state_e;

  // One word of the column memory: the last column and the one before it.
  typedef struct packed {
    logic [CW-1:0] prev;
    logic [CW-1:0] pp;
  } col_word_t;

  // Write request towards the pattern store.
  typedef struct packed {
    logic              en;
    logic              clear;
    logic [CHAR_W-1:0] ch;
  } pat_wr_t;

  // Command of one column walk.
  typedef struct packed {
    logic              start;
    logic              fresh;
    logic [CW-1:0]     n;
    logic [CW-1:0]     j;
    logic [CHAR_W-1:0] c;
    logic [CHAR_W-1:0] prevc;
  } walk_cmd_t;

  // Status of the column walk.
  typedef struct packed {
    logic          done;
    logic [CW-1:0] last_cell;
  } walk_sts_t;

endpackage

/* src/osa_if.sv */
// Handshake interfaces of the input and result channels.
`timescale 1ns / 1ps

interface osa_in_if import osa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [CHAR_W-1:0] ch;
  logic              last;

  modport source (output valid, output op, output ch, output last, input ready);
  modport sink (input valid, input op, input ch, input last, output ready);
endinterface

interface osa_out_if import osa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance;
  logic              overflow;

  modport source (output valid, output distance, output overflow, input ready);
  modport sink (input valid, input distance, input overflow, output ready);
endinterface

/* src/osa_pat_store.sv */
// Pattern memory with its length counter and overflow flag.
`timescale 1ns / 1ps

module osa_pat_store import osa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pat_wr_t           wr_i,
  input  logic [PW-1:0]     raddr_i,
  output logic [CHAR_W-1:0] rdata_o,
  output logic [CW-1:0]     plen_o,
  output logic              povf_o
);

  logic [CHAR_W-1:0] mem [MAX_LEN];
  logic [CHAR_W-1:0] rdata_q;
  logic [CW-1:0]     plen_q, plen_d, len_eff;
  logic              povf_q, povf_d, povf_eff;
  logic              wr_mem;

  always_comb begin
    len_eff  = wr_i.clear ? '0 : plen_q;
    povf_eff = wr_i.clear ? 1'b0 : povf_q;
    wr_mem   = 1'b0;
    plen_d   = plen_q;
    povf_d   = povf_q;
    if (wr_i.en) begin
      plen_d = len_eff;
      povf_d = povf_eff;
      if (len_eff < CW'(MAX_LEN)) begin
        wr_mem = 1'b1;
        plen_d = len_eff + CW'(1);
      end else begin
        povf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_mem) begin
      mem[len_eff[PW-1:0]] <= wr_i.ch;
    end
    rdata_q <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q <= '0;
      povf_q <= 1'b0;
    end else begin
      plen_q <= plen_d;
      povf_q <= povf_d;
    end
  end

  assign rdata_o = rdata_q;
  assign plen_o  = plen_q;
  assign povf_o  = povf_q;

endmodule

/* src/osa_col_unit.sv */
// Column memory and the cell update that walks one DP column per candidate byte.
`timescale 1ns / 1ps

module osa_col_unit import osa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  walk_cmd_t         cmd_i,
  output logic [PW-1:0]     pat_raddr_o,
  input  logic [CHAR_W-1:0] pat_rdata_i,
  output walk_sts_t         sts_o
);

  localparam int SW = CW + 1;

  col_word_t mem [MAX_LEN + 1];
  col_word_t rd_q, wr_word;

  logic          issuing_q, issuing_d;
  logic [CW-1:0] k_q, k_d;
  logic          s1_valid_q;
  logic [CW-1:0] s1_idx_q;

  // Neighbors of the current cell, carried from the previous cell.
  logic [CW-1:0]     prev_im1_q, left_q, pp_d1_q, pp_d2_q;
  logic [CHAR_W-1:0] pm_q;

  logic [CW-1:0] prev_i, v;
  logic [SW-1:0] up, lft, diag, trans, m;
  logic          do_trans;

  // Issue side: one read of the column memory and the pattern memory per cycle.
  always_comb begin
    issuing_d = issuing_q;
    k_d       = k_q;
    if (cmd_i.start) begin
      issuing_d = 1'b1;
      k_d       = '0;
    end else if (issuing_q) begin
      if (k_q == cmd_i.n) begin
        issuing_d = 1'b0;
      end else begin
        k_d = k_q + CW'(1);
      end
    end
  end

  always_comb begin
    if (k_q == '0) begin
      pat_raddr_o = '0;
    end else begin
      pat_raddr_o = PW'(k_q - CW'(1));
    end
  end

  // Cell update. A fresh walk sees the row indices as the previous column.
  always_comb begin
    prev_i   = cmd_i.fresh ? s1_idx_q : rd_q.prev;
    up       = SW'(prev_i) + SW'(1);
    lft      = SW'(left_q) + SW'(1);
    diag     = SW'(prev_im1_q) + ((pat_rdata_i != cmd_i.c) ? SW'(1) : SW'(0));
    trans    = SW'(pp_d2_q) + SW'(1);
    do_trans = (s1_idx_q > CW'(1)) && (cmd_i.j > CW'(1)) &&
               (pm_q == cmd_i.c) && (pat_rdata_i == cmd_i.prevc);
    m = (up < lft) ? up : lft;
    if (diag < m) begin
      m = diag;
    end
    if (do_trans && (trans < m)) begin
      m = trans;
    end
    if (s1_idx_q == '0) begin
      v = cmd_i.j;
    end else begin
      v = m[CW-1:0];
    end
    wr_word.prev = v;
    wr_word.pp   = prev_i;
  end

  // Reads run one cell ahead of the write-back while cells are issued, so no entry is written before it is read.
  always_ff @(posedge clk_i) begin
    rd_q <= mem[k_q];
    if (s1_valid_q) begin
      mem[s1_idx_q] <= wr_word;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      prev_im1_q <= prev_i;
      left_q     <= v;
      pm_q       <= pat_rdata_i;
      pp_d1_q    <= rd_q.pp;
      pp_d2_q    <= pp_d1_q;
    end
    s1_idx_q <= k_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issuing_q  <= 1'b0;
      k_q        <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      issuing_q  <= issuing_d;
      k_q        <= k_d;
      s1_valid_q <= issuing_q;
    end
  end

  assign sts_o.done      = s1_valid_q && (s1_idx_q == cmd_i.n);
  assign sts_o.last_cell = v;

endmodule

/* src/osa_edit_distance.sv */
// Optimal string alignment distance between a stored pattern and streamed candidates.
// Pattern bytes are taken while the block is idle. A candidate byte walks n+1 cells at one per
// cycle, n the stored pattern length, and then passes the finish state; a candidate byte past
// the length limit goes straight to the finish state. No new byte is taken until the finish
// state is left. A final byte's result is loaded there, and that state stalls while an earlier result waits.
// Reset clears lengths, flags and control; the memories are not cleared.
`timescale 1ns / 1ps

module osa_edit_distance import osa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  osa_in_if.sink    in_i,
  osa_out_if.source out_o
);

  osa_state_e state_q, state_d;

  logic [CW-1:0]     pos_q, pos_d;
  logic [CHAR_W-1:0] prevc_q, prevc_d;
  logic              start_new_q, start_new_d;
  logic              ovf_q, ovf_d;
  logic [CHAR_W-1:0] c_q, c_d;
  logic              last_q, last_d;
  logic              fresh_q, fresh_d;
  logic [CW-1:0]     last_cell_q, last_cell_d;

  logic              out_valid_q, out_valid_d;
  logic [DIST_W-1:0] out_dist_q, out_dist_d;
  logic              out_ovf_q, out_ovf_d;

  logic              in_fire, cand_fire, out_free, out_load, walk_start;
  logic              pos_room;
  logic [CW-1:0]     plen;
  logic              povf;
  logic [PW-1:0]     pat_raddr;
  logic [CHAR_W-1:0] pat_rdata;
  pat_wr_t           pat_wr;
  walk_cmd_t         walk_cmd;
  walk_sts_t         walk_sts;

  osa_pat_store u_pat_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (pat_wr),
    .raddr_i (pat_raddr),
    .rdata_o (pat_rdata),
    .plen_o  (plen),
    .povf_o  (povf)
  );

  osa_col_unit u_col_unit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (walk_cmd),
    .pat_raddr_o (pat_raddr),
    .pat_rdata_i (pat_rdata),
    .sts_o       (walk_sts)
  );

  assign in_fire   = in_i.valid && in_i.ready;
  assign cand_fire = in_fire && (in_i.op == OP_CANDIDATE);
  assign pos_room  = pos_q < CW'(MAX_LEN);
  assign out_free  = !out_valid_q || out_o.ready;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cand_fire) begin
          state_d = pos_room ? ST_WALK : ST_FIN;
        end
      end
      ST_WALK: begin
        if (walk_sts.done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!last_q || out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs of the state machine.
  always_comb begin
    in_i.ready = 1'b0;
    walk_start = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        walk_start = cand_fire && pos_room;
      end
      ST_WALK: begin
      end
      ST_FIN: begin
        out_load = last_q && out_free;
      end
      default: begin
      end
    endcase
  end

  assign pat_wr.en    = in_fire && (in_i.op == OP_PATTERN);
  assign pat_wr.clear = start_new_q;
  assign pat_wr.ch    = in_i.ch;

  assign walk_cmd.start = walk_start;
  assign walk_cmd.fresh = fresh_q;
  assign walk_cmd.n     = plen;
  assign walk_cmd.j     = pos_q + CW'(1);
  assign walk_cmd.c     = c_q;
  assign walk_cmd.prevc = prevc_q;

  // Item state.
  always_comb begin
    pos_d       = pos_q;
    prevc_d     = prevc_q;
    start_new_d = start_new_q;
    ovf_d       = ovf_q;
    c_d         = c_q;
    last_d      = last_q;
    fresh_d     = fresh_q;
    last_cell_d = last_cell_q;
    if (pat_wr.en) begin
      // A pattern byte resets the candidate progress.
      pos_d       = '0;
      prevc_d     = '0;
      start_new_d = in_i.last;
    end
    if (cand_fire) begin
      start_new_d = 1'b1;
      c_d         = in_i.ch;
      last_d      = in_i.last;
      fresh_d     = (pos_q == '0);
      if (pos_q == '0) begin
        ovf_d = povf;
      end
      if (!pos_room) begin
        ovf_d = 1'b1;
      end
    end
    if (state_q == ST_WALK && walk_sts.done) begin
      pos_d       = pos_q + CW'(1);
      prevc_d     = c_q;
      last_cell_d = walk_sts.last_cell;
    end
    if (out_load) begin
      pos_d   = '0;
      prevc_d = '0;
      ovf_d   = povf;
    end
  end

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q;
    out_dist_d  = out_dist_q;
    out_ovf_d   = out_ovf_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_ovf_d   = ovf_q;
      if (32'(last_cell_q) > DIST_MAX) begin
        out_dist_d = DIST_W'(DIST_MAX);
      end else begin
        out_dist_d = DIST_W'(last_cell_q);
      end
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      prevc_q     <= '0;
      start_new_q <= 1'b1;
      ovf_q       <= 1'b0;
      last_q      <= 1'b0;
      fresh_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      prevc_q     <= prevc_d;
      start_new_q <= start_new_d;
      ovf_q       <= ovf_d;
      last_q      <= last_d;
      fresh_q     <= fresh_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q         <= c_d;
    last_cell_q <= last_cell_d;
    out_dist_q  <= out_dist_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.distance = out_dist_q;
  assign out_o.overflow = out_ovf_q;

  // The candidate position never passes the length limit.
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= CW'(MAX_LEN))
    else $error("candidate position beyond limit");

  // A candidate beat with room left starts a column walk.
  a_walk_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cand_fire && pos_room) |=> (state_q == ST_WALK))
    else $error("candidate beat did not start a walk");

  // A walk finishes only while the block is walking.
  a_done_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_sts.done |-> (state_q == ST_WALK))
    else $error("walk finished outside of a walk");

  // Loading a result always presents it on the next cycle.
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_o.valid)
    else $error("result was not presented");

endmodule

/* test/osa_edit_distance_tb.sv */
// Self-checking testbench of the edit distance block: random and directed string streams.
`timescale 1ns / 1ps

module osa_edit_distance_tb;
  import osa_pkg::*;

  localparam int RAND_BEATS  = 1850;
  localparam int PHASE_BEATS = 200;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 150;

  typedef struct packed {
    logic              op;
    logic [CHAR_W-1:0] ch;
    logic              last;
  } osa_beat_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              overflow;
  } osa_result_t;

  logic clk_i;
  logic rst_ni;

  osa_in_if  in_if ();
  osa_out_if out_if ();

  osa_edit_distance dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  osa_beat_t   send_q[$];
  osa_result_t dist_exp_q[$];
  int          beats_queued;
  int          beats_taken;
  int          err_cnt;
  int          quiet_cycles;
  osa_result_t exp_r;

  // Shadow copy of the block's state.
  logic [CHAR_W-1:0] pat_mem [MAX_LEN];
  int                pat_len = 0;
  logic [CW-1:0]     col_prev [MAX_LEN+1];
  logic [CW-1:0]     col_pp [MAX_LEN+1] = '{default: '0};
  int                cand_pos = 0;
  logic [CHAR_W-1:0] cand_prev_ch = '0;
  bit                new_pat = 1'b1;
  bit                ovf_cur = 1'b0;
  bit                pat_ovf = 1'b0;

  function automatic int send_idle_pct(input int taken);
    case ((taken / PHASE_BEATS) % 4)
      1: return 45;
      3: return 35;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct(input int taken);
    case ((taken / PHASE_BEATS) % 4)
      2: return 45;
      3: return 35;
      default: return 0;
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] pick_char(input bit narrow);
    if (narrow) begin
      return 8'h61 + CHAR_W'($urandom_range(0, 2));
    end
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  task automatic restart_candidate();
    cand_pos = 0;
    cand_prev_ch = '0;
    ovf_cur = pat_ovf;
    for (int i = 0; i <= MAX_LEN; i++) begin
      col_prev[i] = CW'(i);
    end
  endtask

  // Advances the shadow state by one accepted input beat and queues any result it causes.
  task automatic osa_take_beat(input logic op, input logic [CHAR_W-1:0] c, input logic last);
    logic [CW-1:0] fresh [MAX_LEN+1];
    osa_result_t   r;
    int            j;
    int            v;
    int            diag;
    if (op == OP_PATTERN) begin
      if (new_pat) begin
        pat_len = 0;
        pat_ovf = 1'b0;
        ovf_cur = 1'b0;
        cand_pos = 0;
        cand_prev_ch = '0;
        new_pat = 1'b0;
      end
      if (pat_len < MAX_LEN) begin
        pat_mem[pat_len] = c;
        pat_len++;
      end else begin
        pat_ovf = 1'b1;
      end
      if (last) begin
        new_pat = 1'b1;
        restart_candidate();
      end
    end else begin
      new_pat = 1'b1;
      if (cand_pos == 0) begin
        restart_candidate();
      end
      if (cand_pos < MAX_LEN) begin
        j = cand_pos + 1;
        fresh[0] = CW'(j);
        for (int i = 1; i <= pat_len; i++) begin
          diag = int'(col_prev[i-1]) + ((pat_mem[i-1] != c) ? 1 : 0);
          v = int'(fresh[i-1]) + 1;
          if (int'(col_prev[i]) + 1 < v) v = int'(col_prev[i]) + 1;
          if (diag < v) v = diag;
          // Adjacent swap only once both strings have two characters behind this cell.
          if (i > 1 && j > 1 && pat_mem[i-2] == c && pat_mem[i-1] == cand_prev_ch &&
              int'(col_pp[i-2]) + 1 < v) begin
            v = int'(col_pp[i-2]) + 1;
          end
          fresh[i] = CW'(v);
        end
        col_pp = col_prev;
        for (int i = 0; i <= pat_len; i++) begin
          col_prev[i] = fresh[i];
        end
        cand_pos = j;
        cand_prev_ch = c;
      end else begin
        ovf_cur = 1'b1;
      end
      if (last) begin
        r.distance = DIST_W'(col_prev[pat_len]);
        r.overflow = ovf_cur;
        dist_exp_q.push_back(r);
        restart_candidate();
      end
    end
  endtask

  task automatic push_beat(input logic op, input logic [CHAR_W-1:0] c, input logic last);
    osa_beat_t b;
    b.op = op;
    b.ch = c;
    b.last = last;
    send_q.push_back(b);
    beats_queued++;
  endtask

  task automatic push_text(input logic op, ref logic [CHAR_W-1:0] s[$], input bit close);
    for (int k = 0; k < s.size(); k++) begin
      push_beat(op, s[k], close && (k == s.size() - 1));
    end
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.op = OP_PATTERN;
    in_if.ch = '0;
    in_if.last = 1'b0;
    out_if.ready = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Input driver: a new beat is offered only once the current one has been taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.op <= OP_PATTERN;
      in_if.ch <= '0;
      in_if.last <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (send_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct(beats_taken)) begin
        in_if.valid <= 1'b1;
        in_if.op <= send_q[0].op;
        in_if.ch <= send_q[0].ch;
        in_if.last <= send_q[0].last;
        void'(send_q.pop_front());
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct(beats_taken));
    end
  end

  // Monitor, checker and watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        osa_take_beat(in_if.op, in_if.ch, in_if.last);
        beats_taken++;
      end
      if (out_if.valid && out_if.ready) begin
        if (dist_exp_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("unexpected result: distance %0d overflow %0b",
                     out_if.distance, out_if.overflow);
          end
        end else begin
          exp_r = dist_exp_q.pop_front();
          if (out_if.distance !== exp_r.distance || out_if.overflow !== exp_r.overflow) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("result mismatch: expected distance %0d overflow %0b, got %0d %0b",
                       exp_r.distance, exp_r.overflow, out_if.distance, out_if.overflow);
            end
          end
        end
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    logic [CHAR_W-1:0] pat[$];
    logic [CHAR_W-1:0] cand[$];
    logic [CHAR_W-1:0] t;
    int  len;
    int  kind;
    int  ncand;
    int  pos;
    int  goal;
    bit  narrow;
    bit  cut;
    beats_queued = 0;
    beats_taken = 0;
    err_cnt = 0;
    quiet_cycles = 0;
    restart_candidate();

    // With no pattern stored the distance is the candidate length.
    push_beat(OP_CANDIDATE, 8'h00, 1'b0);
    push_beat(OP_CANDIDATE, 8'hFF, 1'b1);
    // Extreme bytes as pattern; swapped, equal and unrelated candidates.
    push_beat(OP_PATTERN, 8'h00, 1'b0);
    push_beat(OP_PATTERN, 8'hFF, 1'b1);
    push_beat(OP_CANDIDATE, 8'hFF, 1'b0);
    push_beat(OP_CANDIDATE, 8'h00, 1'b1);
    push_beat(OP_CANDIDATE, 8'h00, 1'b0);
    push_beat(OP_CANDIDATE, 8'hFF, 1'b1);
    push_beat(OP_CANDIDATE, 8'h5A, 1'b1);
    // A candidate byte closes a pattern load that was never marked last.
    push_beat(OP_PATTERN, 8'h61, 1'b0);
    push_beat(OP_CANDIDATE, 8'h61, 1'b1);
    // A swap of the first two pattern bytes, then one extra candidate byte.
    push_beat(OP_PATTERN, 8'h62, 1'b0);
    push_beat(OP_PATTERN, 8'h63, 1'b1);
    push_beat(OP_CANDIDATE, 8'h63, 1'b0);
    push_beat(OP_CANDIDATE, 8'h62, 1'b0);
    push_beat(OP_CANDIDATE, 8'h78, 1'b1);
    // A new pattern abandons a candidate in progress.
    push_beat(OP_CANDIDATE, 8'h71, 1'b0);
    push_beat(OP_PATTERN, 8'h7A, 1'b1);
    push_beat(OP_CANDIDATE, 8'h7A, 1'b1);

    goal = beats_queued + RAND_BEATS;
    while (beats_queued < goal) begin
      narrow = $urandom_range(0, 1);
      kind = $urandom_range(0, 99);
      if (kind < 70) len = $urandom_range(1, 10);
      else if (kind < 90) len = $urandom_range(11, 40);
      else if (kind < 96) len = $urandom_range(41, MAX_LEN);
      else len = $urandom_range(MAX_LEN + 1, MAX_LEN + 6);
      pat.delete();
      for (int k = 0; k < len; k++) pat.push_back(pick_char(narrow));
      push_text(OP_PATTERN, pat, $urandom_range(0, 19) != 0);

      ncand = $urandom_range(1, 4);
      for (int n = 0; n < ncand; n++) begin
        kind = $urandom_range(0, 99);
        cand.delete();
        if (kind < 4) begin
          len = $urandom_range(MAX_LEN + 1, MAX_LEN + 6);
          for (int k = 0; k < len; k++) cand.push_back(pick_char(narrow));
        end else if (kind < 10) begin
          len = $urandom_range(1, 12);
          for (int k = 0; k < len; k++) cand.push_back(pick_char(narrow));
        end else begin
          cand = pat;
          repeat ($urandom_range(0, 3)) begin
            if (cand.size() == 0) cand.push_back(pick_char(narrow));
            pos = $urandom_range(0, cand.size() - 1);
            case ($urandom_range(0, 3))
              0: cand[pos] = pick_char(narrow);
              1: cand.insert(pos, pick_char(narrow));
              2: cand.delete(pos);
              default: begin
                if (pos + 1 < cand.size()) begin
                  t = cand[pos];
                  cand[pos] = cand[pos+1];
                  cand[pos+1] = t;
                end
              end
            endcase
          end
        end
        if (cand.size() == 0) cand.push_back(pick_char(narrow));
        cut = ($urandom_range(0, 24) == 0);
        push_text(OP_CANDIDATE, cand, !cut);
        if (cut) break;
      end
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (send_q.size() != 0 || in_if.valid) @(posedge clk_i);
    while (dist_exp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0 && dist_exp_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* files.f */
src/osa_pkg.sv
src/osa_if.sv
src/osa_pat_store.sv
src/osa_col_unit.sv
src/osa_edit_distance.sv
test/osa_edit_distance_tb.sv
